### sv/mst_pkg.sv
package mst_pkg;

	localparam logic [3:0] K_TEXT    = 4'd0;
	localparam logic [3:0] K_COMMENT = 4'd1;
	localparam logic [3:0] K_CDATA   = 4'd2;
	localparam logic [3:0] K_DOCTYPE = 4'd3;
	localparam logic [3:0] K_PUNCT   = 4'd4;
	localparam logic [3:0] K_TAG     = 4'd5;
	localparam logic [3:0] K_ATTR    = 4'd6;
	localparam logic [3:0] K_OPER    = 4'd7;
	localparam logic [3:0] K_VALUE   = 4'd8;
	localparam logic [3:0] K_ENTITY  = 4'd9;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef enum logic [3:0] {
		M_TEXT, M_TEXT_RUN, M_LT, M_BANG, M_ENT, M_COMMENT, M_CDATA, M_DOCT,
		M_TAG_OPEN, M_TAG_NAME, M_ATTR, M_AFTER_EQ, M_UVAL, M_QVAL, M_POSTVAL
	} mode_t;

	typedef enum logic [2:0] {
		C_IDLE, C_EVAL, C_FL_RD, C_FL_PUT, C_EOI, C_FIN
	} cstate_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [3:0] token_kind;
		logic       token_start;
		logic       last_result;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic apply;
		logic sel_eoi;
		logic fl_put;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic put;
		logic flush;
		logic done;
		logic can_put;
		logic fin_ok;
		logic fl_last;
		logic eoi;
	} sts_t;

	function automatic logic is_name_core(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h30 && b <= 8'h39) || b == 8'h5F;
	endfunction

	function automatic logic is_name(input logic [7:0] b);
		return is_name_core(b) || b == CH_DASH || b == 8'h3A;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0C || b == 8'h0B;
	endfunction

	function automatic logic [7:0] cmt_char(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0: c = CH_LT;
			2'd1: c = CH_BANG;
			default: c = CH_DASH;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] cdata_char(input logic [3:0] i);
		logic [7:0] c;
		case (i)
			4'd0: c = CH_LT;
			4'd1: c = CH_BANG;
			4'd2: c = CH_LBRK;
			4'd3: c = 8'h43;
			4'd4: c = 8'h44;
			4'd5: c = 8'h41;
			4'd6: c = 8'h54;
			4'd7: c = 8'h41;
			4'd8: c = CH_LBRK;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### sv/mst_ram.sv
module mst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/mst_ctrl.sv
module mst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  mst_pkg::sts_t sts,
	output mst_pkg::cmd_t cmd,
	output logic          busy
);

	mst_pkg::cstate_t state_q, state_d;
	logic ret_eoi_q, ret_eoi_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mst_pkg::C_IDLE;
			ret_eoi_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_eoi_q <= ret_eoi_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_eoi_d = ret_eoi_q;
		case (state_q)
			mst_pkg::C_IDLE: begin
				if (in_valid) state_d = mst_pkg::C_EVAL;
			end
			mst_pkg::C_EVAL: begin
				if (!(sts.put && !sts.can_put)) begin
					if (sts.flush) begin
						state_d   = mst_pkg::C_FL_RD;
						ret_eoi_d = 1'b0;
					end else if (sts.done) begin
						state_d = sts.eoi ? mst_pkg::C_EOI : mst_pkg::C_FIN;
					end
				end
			end
			mst_pkg::C_FL_RD: state_d = mst_pkg::C_FL_PUT;
			mst_pkg::C_FL_PUT: begin
				if (sts.can_put) begin
					if (sts.fl_last) begin
						state_d = ret_eoi_q ? mst_pkg::C_FIN : mst_pkg::C_EVAL;
					end else begin
						state_d = mst_pkg::C_FL_RD;
					end
				end
			end
			mst_pkg::C_EOI: begin
				if (!(sts.put && !sts.can_put)) begin
					if (sts.flush) begin
						state_d   = mst_pkg::C_FL_RD;
						ret_eoi_d = 1'b1;
					end else begin
						state_d = mst_pkg::C_FIN;
					end
				end
			end
			mst_pkg::C_FIN: begin
				if (sts.fin_ok) state_d = mst_pkg::C_IDLE;
			end
			default: state_d = mst_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			mst_pkg::C_IDLE: begin
				busy     = 1'b0;
				cmd.load = in_valid;
			end
			mst_pkg::C_EVAL: cmd.apply = !(sts.put && !sts.can_put);
			mst_pkg::C_FL_PUT: cmd.fl_put = sts.can_put;
			mst_pkg::C_EOI: begin
				cmd.sel_eoi = 1'b1;
				cmd.apply   = !(sts.put && !sts.can_put);
			end
			mst_pkg::C_FIN: cmd.fin = sts.fin_ok;
			default: cmd = '0;
		endcase
	end

endmodule

### sv/mst_dp.sv
module mst_dp #(
	parameter int HOLD_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mst_pkg::cmd_t      cmd,
	input  mst_pkg::in_item_t  in_item,
	input  logic               out_stall,
	output mst_pkg::sts_t      sts,
	output logic               out_valid,
	output mst_pkg::out_item_t out_item
);

	localparam int AW = $clog2(HOLD_DEPTH);
	localparam int CW = $clog2(HOLD_DEPTH + 1);

	logic [7:0]     b_q;
	logic           eoi_q;
	mst_pkg::mode_t mode_q, mode_d, pm_q, pm_d;
	logic [CW-1:0]  hc_q, hc_d, fl_cnt_q;
	logic [7:0]     quote_q, quote_d;
	logic           esc_q, esc_d, cd_q, cd_d, pv_q, pv_d;
	logic [1:0]     close_q, close_d;
	logic [3:0]     prev_q, pk_q, pk_d, fl_kind_q;
	logic [AW-1:0]  fl_idx_q;
	logic           fl_ent_q;

	logic           dput, dlt, dstart, dflush, dfent, ddone, dwr;
	logic [3:0]     dkind, dfkind;
	logic [AW-1:0]  dwaddr;
	logic [7:0]     rdata;

	mst_pkg::out_item_t stage_q, nr;
	logic           stage_v_q, out_v_q, out_free, do_put, fl_start, cmt_m, cdata_m, val_ok;
	logic [7:0]     sterm;
	logic [3:0]     skind;

	mst_ram #(.WIDTH(8), .DEPTH(HOLD_DEPTH)) u_hold (
		.clk  (clk),
		.we   (cmd.apply && dwr),
		.waddr(dwaddr),
		.wdata(b_q),
		.raddr(fl_idx_q),
		.rdata(rdata)
	);

	// the held bytes of a bang prefix always match one of the two patterns
	always_comb begin
		cmt_m = (hc_q <= CW'(3)) && (hc_q <= CW'(2) || !cd_q) &&
			mst_pkg::cmt_char(hc_q[1:0]) == b_q;
		cdata_m = (hc_q <= CW'(8)) && (hc_q <= CW'(2) || cd_q) &&
			mst_pkg::cdata_char(hc_q[3:0]) == b_q;
		val_ok = !mst_pkg::is_blank(b_q) && b_q != mst_pkg::CH_GT &&
			b_q != mst_pkg::CH_SLASH && b_q != mst_pkg::CH_NL;
		sterm = (mode_q == mst_pkg::M_COMMENT) ? mst_pkg::CH_DASH : mst_pkg::CH_RBRK;
		skind = (mode_q == mst_pkg::M_COMMENT) ? mst_pkg::K_COMMENT : mst_pkg::K_CDATA;
	end

	always_comb begin
		dput = 1'b0; dlt = 1'b0; dkind = mst_pkg::K_TEXT; dstart = 1'b0;
		dflush = 1'b0; dfent = 1'b0; dfkind = mst_pkg::K_TEXT; ddone = 1'b0;
		dwr = 1'b0; dwaddr = hc_q[AW-1:0];
		mode_d = mode_q; hc_d = hc_q; quote_d = quote_q; esc_d = esc_q;
		close_d = close_q; pv_d = pv_q; pk_d = pk_q; pm_d = pm_q; cd_d = cd_q;
		if (cmd.sel_eoi) begin
			ddone = 1'b1;
			case (mode_q)
				mst_pkg::M_LT: begin
					dput = 1'b1; dlt = 1'b1; dkind = mst_pkg::K_PUNCT; dstart = 1'b1;
					hc_d = '0;
				end
				mst_pkg::M_BANG: begin
					dflush = 1'b1; dfkind = mst_pkg::K_DOCTYPE; hc_d = '0;
				end
				mst_pkg::M_ENT: begin
					dflush = 1'b1; dfent = 1'b1; dfkind = mst_pkg::K_TEXT; hc_d = '0;
				end
				default: ddone = 1'b1;
			endcase
		end else if (pv_q) begin
			// byte that follows a flushed prefix or a two-byte opener
			dput = 1'b1; dkind = pk_q; mode_d = pm_q; close_d = '0; pv_d = 1'b0;
			ddone = 1'b1;
		end else begin
			case (mode_q)
				mst_pkg::M_TEXT, mst_pkg::M_TEXT_RUN: begin
					ddone = 1'b1;
					if (b_q == mst_pkg::CH_NL) begin
						dput = 1'b1; dstart = 1'b1; mode_d = mst_pkg::M_TEXT;
					end else if (b_q == mst_pkg::CH_LT || b_q == mst_pkg::CH_AMP) begin
						dwr = 1'b1; dwaddr = '0; hc_d = CW'(1);
						mode_d = (b_q == mst_pkg::CH_LT) ? mst_pkg::M_LT : mst_pkg::M_ENT;
					end else begin
						dput = 1'b1; dstart = (mode_q == mst_pkg::M_TEXT);
						mode_d = mst_pkg::M_TEXT_RUN;
					end
				end
				mst_pkg::M_LT: begin
					if (b_q == mst_pkg::CH_BANG) begin
						dwr = 1'b1; dwaddr = AW'(1); hc_d = CW'(2);
						mode_d = mst_pkg::M_BANG; ddone = 1'b1;
					end else if (b_q == mst_pkg::CH_QUEST) begin
						dput = 1'b1; dlt = 1'b1; dkind = mst_pkg::K_DOCTYPE; dstart = 1'b1;
						hc_d = '0; pv_d = 1'b1; pk_d = mst_pkg::K_DOCTYPE;
						pm_d = mst_pkg::M_DOCT;
					end else begin
						dput = 1'b1; dlt = 1'b1; dkind = mst_pkg::K_PUNCT; dstart = 1'b1;
						hc_d = '0; mode_d = mst_pkg::M_TAG_OPEN;
					end
				end
				mst_pkg::M_BANG: begin
					if (cmt_m) begin
						if (hc_q == CW'(3)) begin
							dflush = 1'b1; dfkind = mst_pkg::K_COMMENT; hc_d = '0;
							pv_d = 1'b1; pk_d = mst_pkg::K_COMMENT;
							pm_d = mst_pkg::M_COMMENT;
						end else begin
							dwr = 1'b1; hc_d = hc_q + CW'(1); ddone = 1'b1;
							if (hc_q == CW'(2)) cd_d = 1'b0;
						end
					end else if (cdata_m) begin
						if (hc_q == CW'(8)) begin
							dflush = 1'b1; dfkind = mst_pkg::K_CDATA; hc_d = '0;
							pv_d = 1'b1; pk_d = mst_pkg::K_CDATA; pm_d = mst_pkg::M_CDATA;
						end else begin
							dwr = 1'b1; hc_d = hc_q + CW'(1); ddone = 1'b1;
							if (hc_q == CW'(2)) cd_d = 1'b1;
						end
					end else begin
						dflush = 1'b1; dfkind = mst_pkg::K_DOCTYPE; hc_d = '0;
						pv_d = 1'b1; pk_d = mst_pkg::K_DOCTYPE;
						pm_d = (b_q == mst_pkg::CH_GT) ? mst_pkg::M_TEXT : mst_pkg::M_DOCT;
					end
				end
				mst_pkg::M_ENT: begin
					if (b_q == mst_pkg::CH_SEMI) begin
						dflush = 1'b1; dfkind = mst_pkg::K_ENTITY; hc_d = '0;
						pv_d = 1'b1; pk_d = mst_pkg::K_ENTITY; pm_d = mst_pkg::M_TEXT;
					end else if (mst_pkg::is_name_core(b_q) ||
						(b_q == mst_pkg::CH_HASH && hc_q == CW'(1))) begin
						if (hc_q < CW'(HOLD_DEPTH)) begin
							dwr = 1'b1; hc_d = hc_q + CW'(1); ddone = 1'b1;
						end else begin
							// entity longer than the hold buffer
							dflush = 1'b1; dfent = 1'b1; hc_d = '0;
							pv_d = 1'b1; pk_d = mst_pkg::K_TEXT; pm_d = mst_pkg::M_TEXT_RUN;
						end
					end else begin
						dflush = 1'b1; dfent = 1'b1; hc_d = '0;
						mode_d = (hc_q > CW'(1)) ? mst_pkg::M_TEXT_RUN : mst_pkg::M_TEXT;
					end
				end
				mst_pkg::M_COMMENT, mst_pkg::M_CDATA: begin
					dput = 1'b1; ddone = 1'b1;
					if (b_q == mst_pkg::CH_NL) begin
						dstart = 1'b1; close_d = '0;
					end else begin
						dkind = skind; dstart = (prev_q != skind);
						if (b_q == sterm) begin
							if (close_q < 2'd2) close_d = close_q + 2'd1;
						end else if (b_q == mst_pkg::CH_GT && close_q == 2'd2) begin
							close_d = '0; mode_d = mst_pkg::M_TEXT;
						end else begin
							close_d = '0;
						end
					end
				end
				mst_pkg::M_DOCT: begin
					dput = 1'b1; dkind = mst_pkg::K_DOCTYPE; ddone = 1'b1;
					if (b_q == mst_pkg::CH_GT) mode_d = mst_pkg::M_TEXT;
				end
				mst_pkg::M_TAG_OPEN: begin
					mode_d = mst_pkg::M_TAG_NAME;
					if (b_q == mst_pkg::CH_SLASH) begin
						dput = 1'b1; dkind = mst_pkg::K_PUNCT; dstart = 1'b1; ddone = 1'b1;
					end
				end
				mst_pkg::M_TAG_NAME: begin
					if (mst_pkg::is_name(b_q)) begin
						dput = 1'b1; dkind = mst_pkg::K_TAG;
						dstart = (prev_q != mst_pkg::K_TAG); ddone = 1'b1;
					end else begin
						mode_d = mst_pkg::M_ATTR;
					end
				end
				mst_pkg::M_ATTR: begin
					dput = 1'b1; ddone = 1'b1;
					if (b_q == mst_pkg::CH_GT || b_q == mst_pkg::CH_NL) begin
						dkind = (b_q == mst_pkg::CH_GT) ? mst_pkg::K_PUNCT : mst_pkg::K_TEXT;
						dstart = 1'b1; mode_d = mst_pkg::M_TEXT;
					end else if (mst_pkg::is_blank(b_q)) begin
						dstart = (prev_q != mst_pkg::K_TEXT);
					end else if (b_q == mst_pkg::CH_SLASH) begin
						dkind = mst_pkg::K_PUNCT; dstart = 1'b1;
					end else if (mst_pkg::is_name(b_q)) begin
						dkind = mst_pkg::K_ATTR; dstart = (prev_q != mst_pkg::K_ATTR);
					end else begin
						dkind = mst_pkg::K_OPER; dstart = 1'b1;
						if (b_q == mst_pkg::CH_EQ) mode_d = mst_pkg::M_AFTER_EQ;
					end
				end
				mst_pkg::M_AFTER_EQ: begin
					if (b_q == mst_pkg::CH_DQ || b_q == mst_pkg::CH_SQ) begin
						quote_d = b_q; esc_d = 1'b0;
						dput = 1'b1; dkind = mst_pkg::K_VALUE; dstart = 1'b1; ddone = 1'b1;
						mode_d = mst_pkg::M_QVAL;
					end else if (val_ok) begin
						dput = 1'b1; dkind = mst_pkg::K_VALUE; dstart = 1'b1; ddone = 1'b1;
						mode_d = mst_pkg::M_UVAL;
					end else begin
						mode_d = mst_pkg::M_ATTR;
					end
				end
				mst_pkg::M_UVAL: begin
					if (val_ok) begin
						dput = 1'b1; dkind = mst_pkg::K_VALUE; ddone = 1'b1;
					end else begin
						mode_d = mst_pkg::M_ATTR;
					end
				end
				mst_pkg::M_QVAL: begin
					dput = 1'b1; ddone = 1'b1;
					if (b_q == mst_pkg::CH_NL) begin
						dstart = 1'b1; esc_d = 1'b0;
					end else begin
						dkind = mst_pkg::K_VALUE; dstart = (prev_q != mst_pkg::K_VALUE);
						if (esc_q) begin
							esc_d = 1'b0;
						end else if (b_q == mst_pkg::CH_BSL) begin
							esc_d = 1'b1;
						end else if (b_q == quote_q) begin
							mode_d = mst_pkg::M_POSTVAL;
						end
					end
				end
				mst_pkg::M_POSTVAL: begin
					mode_d = mst_pkg::M_ATTR;
					if (b_q != mst_pkg::CH_GT && !mst_pkg::is_blank(b_q) &&
						b_q != mst_pkg::CH_NL && b_q != mst_pkg::CH_EQ &&
						b_q != mst_pkg::CH_SLASH) begin
						dput = 1'b1; dkind = mst_pkg::K_OPER; dstart = 1'b1; ddone = 1'b1;
					end
				end
				default: mode_d = mst_pkg::M_TEXT;
			endcase
		end
	end

	assign out_free = !out_v_q || !out_stall;
	assign fl_start = fl_ent_q ? (fl_idx_q <= AW'(1)) : (fl_idx_q == '0);
	assign do_put   = (cmd.apply && dput) || cmd.fl_put;

	always_comb begin
		nr.out_byte    = cmd.fl_put ? rdata : (dlt ? mst_pkg::CH_LT : b_q);
		nr.token_kind  = cmd.fl_put ? fl_kind_q : dkind;
		nr.token_start = cmd.fl_put ? fl_start : dstart;
		nr.last_result = 1'b0;
	end

	always_comb begin
		sts.put     = dput;
		sts.flush   = dflush;
		sts.done    = ddone;
		sts.can_put = !stage_v_q || out_free;
		sts.fin_ok  = !stage_v_q || out_free;
		sts.fl_last = (CW'(fl_idx_q) == fl_cnt_q - CW'(1));
		sts.eoi     = eoi_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mst_pkg::M_TEXT; hc_q <= '0; quote_q <= '0; esc_q <= 1'b0;
			close_q <= '0; prev_q <= mst_pkg::K_TEXT; pv_q <= 1'b0;
			pk_q <= mst_pkg::K_TEXT; pm_q <= mst_pkg::M_TEXT; cd_q <= 1'b0;
			stage_v_q <= 1'b0; out_v_q <= 1'b0;
			fl_idx_q <= '0; fl_cnt_q <= '0; fl_ent_q <= 1'b0; fl_kind_q <= mst_pkg::K_TEXT;
		end else begin
			if (cmd.apply) begin
				mode_q <= mode_d; hc_q <= hc_d; quote_q <= quote_d; esc_q <= esc_d;
				close_q <= close_d; pv_q <= pv_d; pk_q <= pk_d; pm_q <= pm_d; cd_q <= cd_d;
				if (dflush) begin
					fl_cnt_q <= hc_q; fl_idx_q <= '0; fl_ent_q <= dfent; fl_kind_q <= dfkind;
				end
			end
			if (cmd.fl_put) fl_idx_q <= fl_idx_q + AW'(1);
			if (do_put) prev_q <= nr.token_kind;

			if ((do_put || cmd.fin) && stage_v_q) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			if (do_put) begin
				stage_v_q <= 1'b1;
			end else if (cmd.fin && stage_v_q) begin
				stage_v_q <= 1'b0;
			end

			// end of stream: back to the reset state for the next stream
			if (cmd.fin && eoi_q) begin
				mode_q <= mst_pkg::M_TEXT; hc_q <= '0; quote_q <= '0; esc_q <= 1'b0;
				close_q <= '0; prev_q <= mst_pkg::K_TEXT; pv_q <= 1'b0; cd_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			b_q   <= in_item.in_byte;
			eoi_q <= in_item.end_of_input;
		end
		if (do_put) begin
			stage_q <= nr;
		end
		if (do_put && stage_v_q) begin
			out_item <= stage_q;
		end else if (cmd.fin && stage_v_q) begin
			out_item <= {stage_q.out_byte, stage_q.token_kind, stage_q.token_start, eoi_q};
		end
	end

	assign out_valid = out_v_q;

endmodule

### sv/markup_syntax_tokenizer_core.sv
// Markup tokenizer: classifies a stream of HTML, XML or SVG source bytes.
// Input channel byte_*: one source byte per transaction, with end_of_input
// set on the last byte of a stream. Output channel tok_*: one transaction
// per classified byte carrying the byte, its token kind and a token-start
// flag; last_result marks the final transaction of a stream.
// A byte passes through the controller's accept, evaluate and finish
// steps; a byte that steps through several tag sub-modes is evaluated
// once per sub-mode. Bytes held for a "<!" prefix or an "&" entity leave
// as a burst, each byte passing through a read state and a put state,
// paced by the registered read of the hold buffer.
// byte_stall is high whenever an item is in work. A stall on the output
// side holds the output register and, once the staging register is full,
// the whole sequencer; nothing is dropped.
// Reset returns the block to content text mode with no held bytes; the
// same happens after each byte flagged end_of_input.
module markup_syntax_tokenizer_core #(
	parameter int HOLD_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  mst_pkg::in_item_t  byte_item,
	output logic               tok_valid,
	input  logic               tok_stall,
	output mst_pkg::out_item_t tok_item
);

	mst_pkg::cmd_t cmd;
	mst_pkg::sts_t sts;

	mst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(byte_valid),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (byte_stall)
	);

	mst_dp #(.HOLD_DEPTH(HOLD_DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (byte_item),
		.out_stall(tok_stall),
		.sts      (sts),
		.out_valid(tok_valid),
		.out_item (tok_item)
	);

endmodule
